// ===== rtl/core/assert_macros.svh =====
// assertion helpers, clocked on clk and disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/core/mavg_pkg.sv =====
package mavg_pkg;

  localparam int MAX_WINDOW   = 32;
  localparam int SAMPLE_W     = 16;
  localparam int CFG_W        = 6;
  localparam int HIST_AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W        = SAMPLE_W + HIST_AW;
  localparam int STEP_W       = $clog2(SUM_W);
  localparam int WINDOW_RESET = 8;

  // window length clamped to 1..MAX_WINDOW
  function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] wl);
    logic [CNT_W-1:0] n;
    if (wl == '0) begin
      n = CNT_W'(1);
    end else if (int'(wl) > MAX_WINDOW) begin
      n = CNT_W'(MAX_WINDOW);
    end else begin
      n = CNT_W'(int'(wl));
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/mavg_ram.sv =====
module mavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/moving_average_filter_core.sv =====
// channel  | dir | tdata bits        | tuser / tlast
// s_axis   | in  | [15:0] sample     | none
// m_axis   | out | [15:0] average    | none
// cfg      | in  | [5:0] window_len  | write enable only
//
// a request goes from accept to the result register: one cycle per history
// read through the sample memory port for its n words (n = window length,
// 1..32), then one quotient bit per cycle of the divider over the 21-bit sum.
// rst is synchronous: history reads as zero until written, window length 8.
// a finished result waits in the output register; the next sample is taken
// meanwhile, and the divider holds its result until the register is free.
`include "assert_macros.svh"

module moving_average_filter_core
  import mavg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,  // [15:0] sample
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,  // [15:0] average
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]            state;
  logic [CFG_W-1:0]      window_len;
  logic [CNT_W-1:0]      n_eff;
  logic [HIST_AW-1:0]    wp;
  logic [HIST_AW-1:0]    rd_ptr;
  logic [MAX_WINDOW-1:0] hvalid;
  logic                  rd_vld;
  logic [SAMPLE_W-1:0]   rdata;
  logic [CNT_W-1:0]      cnt;
  logic signed [SUM_W-1:0] acc;
  logic [SUM_W-1:0]      quo;
  logic [CNT_W-1:0]      rem;
  logic [STEP_W-1:0]     step;
  logic                  neg;
  logic                  accept;
  logic [SAMPLE_W-1:0]   hist_word;
  logic [CNT_W:0]        trial;
  logic                  trial_ge;
  logic [SUM_W-1:0]      quo_next;
  logic [SUM_W-1:0]      signed_quo;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign n_eff         = eff_window(window_len);

  mavg_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (s_axis_tdata),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  // never-written entries read as zero
  assign hist_word = rd_vld ? rdata : '0;

  // restoring divide step
  assign trial    = {rem, quo[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, n_eff});
  assign quo_next = {quo[SUM_W-2:0], trial_ge};
  assign signed_quo = neg ? (~quo + SUM_W'(1)) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_len    <= CFG_W'(WINDOW_RESET);
      wp            <= '0;
      hvalid        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_len <= cfg_wr_data;
      end
      // a new result in S_OUT takes over the register in the same cycle
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            hvalid[wp] <= 1'b1;
            state      <= S_SUM;
          end
        end
        S_SUM: begin
          if (cnt == n_eff) begin
            wp    <= (int'(wp) == MAX_WINDOW - 1) ? '0 : wp + HIST_AW'(1);
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (int'(step) == SUM_W - 1) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rd_vld <= hvalid[rd_ptr];
    unique case (state)
      S_IDLE: begin
        rd_ptr <= wp;
        cnt    <= '0;
        acc    <= '0;
      end
      S_SUM: begin
        // read issued at cnt, its word lands in the next cycle
        if (cnt != '0) begin
          acc <= acc + SUM_W'(signed'(hist_word));
        end
        if (cnt != n_eff) begin
          rd_ptr <= (rd_ptr == '0) ? HIST_AW'(MAX_WINDOW - 1) : rd_ptr - HIST_AW'(1);
          cnt    <= cnt + CNT_W'(1);
        end
      end
      S_PREP: begin
        neg  <= acc[SUM_W-1];
        quo  <= acc[SUM_W-1] ? (~acc + SUM_W'(1)) : acc;
        rem  <= '0;
        step <= '0;
      end
      S_DIV: begin
        quo  <= quo_next;
        rem  <= trial_ge ? CNT_W'(trial - {1'b0, n_eff}) : trial[CNT_W-1:0];
        step <= step + STEP_W'(1);
      end
      S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= signed_quo[SAMPLE_W-1:0];
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

  `ASSERT_HOLDS(a_accept_starts_sum, accept |=> (state == S_SUM), "accept must start summing")
  `ASSERT_NEVER(a_cnt_in_window, (state == S_SUM) && (cnt > n_eff), "sum count past window")
  `ASSERT_NEVER(a_step_bound, (state == S_DIV) && (int'(step) >= SUM_W), "divider overran")
  `ASSERT_HOLDS(a_result_from_out, $rose(m_axis_tvalid) |-> ($past(state) == S_OUT),
                "result shown without finishing divide")

endmodule
